// ===== sv/wlrr_pkg.sv =====
// Shared types and constants for the wear-leveling record ring.
// Used by the front end, engine, remainder unit and top level.
package wlrr_pkg;

	localparam int STORE_DEPTH_DEF = 256;
	localparam int MAX_RECORD_DEF  = 64;

	localparam int FUNC_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int POS_W    = 6;
	localparam int INDEX_W  = 8;
	localparam int BLOCK_W  = 9;
	localparam int RECORD_W = 7;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// width of index + offset sums and of the remainder datapath
	localparam int SUM_W  = 9;
	localparam int STEP_W = $clog2(SUM_W + 1);

	localparam int CMD_FIFO_AW = 1;
	localparam int OUT_FIFO_AW = 2;

	localparam logic [FUNC_W-1:0] FUNC_RESCAN = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECORD_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY_VALUE = 2'd2;

	localparam logic [BLOCK_W-1:0]  BLOCK_RESET  = 9'd256;
	localparam logic [RECORD_W-1:0] RECORD_RESET = 7'd1;
	localparam logic [BYTE_W-1:0]   EMPTY_RESET  = 8'hFF;
	localparam logic [BYTE_W-1:0]   ERASED_BYTE  = 8'hFF;

	typedef enum logic [1:0] {
		OP_SCAN,
		OP_READ,
		OP_WRITE
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RD_MOD,
		ST_RD_WALK,
		ST_ER_MOD,
		ST_ERASE,
		ST_WR_MOD
	} state_t;

	typedef struct packed {
		logic [BLOCK_W-1:0]  block_size;
		logic [RECORD_W-1:0] record_size;
		logic [BYTE_W-1:0]   empty_value;
	} cfg_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data;
		logic [POS_W-1:0]  pos;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic [INDEX_W-1:0] index;
		logic               last;
	} res_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] x;
		logic [SUM_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] rem;
	} mod_rsp_t;

endpackage

// ===== sv/wlrr_front.sv =====
// Front end: accepts input transactions and decodes them into queue commands.
// Depends on wlrr_pkg; feeds the command queue.
module wlrr_front (
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [wlrr_pkg::FUNC_W-1:0]   func,
	input  logic [wlrr_pkg::BYTE_W-1:0]   data_byte,
	input  logic [wlrr_pkg::POS_W-1:0]    byte_position,
	input  logic                          cmd_full,
	output logic                          cmd_push,
	output wlrr_pkg::cmd_t                cmd
);

	logic known;

	always_comb begin
		known  = 1'b1;
		cmd.op = wlrr_pkg::OP_SCAN;
		case (func)
			wlrr_pkg::FUNC_RESCAN: cmd.op = wlrr_pkg::OP_SCAN;
			wlrr_pkg::FUNC_READ:   cmd.op = wlrr_pkg::OP_READ;
			wlrr_pkg::FUNC_WRITE:  cmd.op = wlrr_pkg::OP_WRITE;
			default:               known  = 1'b0;  // unused selector, dropped
		endcase
		cmd.data = data_byte;
		cmd.pos  = byte_position;
	end

	assign in_stall = cmd_full;
	assign cmd_push = in_valid && !cmd_full && known;

endmodule

// ===== sv/wlrr_fifo.sv =====
// Small register FIFO, 2**AW entries, used for the command and result queues.
// Depends on no package.
module wlrr_fifo #(
	parameter int WIDTH = 8,
	parameter int AW    = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty,
	output logic [AW:0]      level
);

	localparam int DEPTH = 2 ** AW;

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      level_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (level_q == (AW+1)'(DEPTH));
	assign empty    = (level_q == '0);
	assign level    = level_q;
	assign pop_data = store_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				level_q <= level_q + 1'b1;
			else if (do_pop && !do_push)
				level_q <= level_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			store_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== sv/wlrr_mod.sv =====
// Serial remainder unit: x mod divisor, one restoring step per cycle.
// Depends on wlrr_pkg; used by the engine to wrap record start and write addresses into the ring.
module wlrr_mod (
	input  logic               clk,
	input  logic               arst_n,
	input  wlrr_pkg::mod_req_t req,
	output wlrr_pkg::mod_rsp_t rsp
);

	localparam int W = wlrr_pkg::SUM_W;

	logic [W-1:0]                  rem_q;
	logic [W-1:0]                  x_q;
	logic [W-1:0]                  div_q;
	logic [wlrr_pkg::STEP_W-1:0]   cnt_q;
	logic                          done_q;
	logic [W:0]                    trial;
	logic [W:0]                    diff;
	logic [W-1:0]                  rem_d;

	always_comb begin
		trial = {rem_q, x_q[W-1]};
		diff  = trial - {1'b0, div_q};
		if (trial >= {1'b0, div_q})
			rem_d = diff[W-1:0];
		else
			rem_d = trial[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && (cnt_q == wlrr_pkg::STEP_W'(1));
			if (req.start)
				cnt_q <= wlrr_pkg::STEP_W'(W);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			x_q   <= req.x;
			div_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= rem_d;
			x_q   <= {x_q[W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== sv/wlrr_engine.sv =====
// Back end: ring store, record index and the sequencer for rescan, read and write.
// Depends on wlrr_pkg; drives the remainder unit and the result queue.
module wlrr_engine #(
	parameter int STORE_DEPTH = wlrr_pkg::STORE_DEPTH_DEF,
	parameter int MAX_RECORD  = wlrr_pkg::MAX_RECORD_DEF,
	parameter int OUT_AW      = wlrr_pkg::OUT_FIFO_AW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wlrr_pkg::cfg_t     cfg,
	input  logic               cmd_empty,
	input  wlrr_pkg::cmd_t     cmd_head,
	output logic               cmd_pop,
	input  logic [OUT_AW:0]    out_level,
	output logic               res_push,
	output wlrr_pkg::res_t     res,
	output wlrr_pkg::mod_req_t mod_req,
	input  wlrr_pkg::mod_rsp_t mod_rsp
);

	localparam int AW        = $clog2(STORE_DEPTH);
	localparam int CW        = AW + 1;
	localparam int RW        = $clog2(MAX_RECORD + 1);
	localparam int OUT_DEPTH = 2 ** OUT_AW;
	localparam int LW        = OUT_AW + 2;
	localparam int SW        = wlrr_pkg::SUM_W;

	wlrr_pkg::state_t state_q, state_d;
	wlrr_pkg::cmd_t   cur_q;

	logic [wlrr_pkg::BYTE_W-1:0] mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0]      vbit_q;

	logic [AW-1:0] idx_q;
	logic [AW-1:0] walk_e_q;
	logic [RW-1:0] walk_k_q;
	logic [CW-1:0] scan_n_q;

	logic                        rd_vld_s1;
	logic [AW-1:0]               rd_addr_s1;
	logic                        rd_last_s1;
	logic [wlrr_pkg::BYTE_W-1:0] rd_data_s1;
	logic                        rd_vb_s1;

	logic [CW-1:0]               bs_eff;
	logic [RW-1:0]               rs_eff;
	logic [CW-1:0]               e_plus;
	logic [AW-1:0]               e_next;
	logic [wlrr_pkg::BYTE_W-1:0] rd_byte;
	logic                        scan_hit;
	logic                        scan_end;
	logic                        go;
	logic                        walk_last;
	logic                        out_room;

	logic                        rd_issue;
	logic [AW-1:0]               rd_addr;
	logic                        rd_last;
	logic                        mem_we;
	logic [AW-1:0]               mem_wa;
	logic [wlrr_pkg::BYTE_W-1:0] mem_wd;

	// effective sizes: zero reads as one, oversize clamps
	always_comb begin
		if (cfg.block_size == '0)
			bs_eff = CW'(1);
		else if (cfg.block_size > wlrr_pkg::BLOCK_W'(STORE_DEPTH))
			bs_eff = CW'(STORE_DEPTH);
		else
			bs_eff = cfg.block_size[CW-1:0];
		if (cfg.record_size == '0)
			rs_eff = RW'(1);
		else if (cfg.record_size > wlrr_pkg::RECORD_W'(MAX_RECORD))
			rs_eff = RW'(MAX_RECORD);
		else
			rs_eff = cfg.record_size[RW-1:0];
	end

	// ring walk pointer steps by one and wraps at the block size
	assign e_plus    = {1'b0, walk_e_q} + 1'b1;
	assign e_next    = (e_plus == bs_eff) ? '0 : e_plus[AW-1:0];
	assign walk_last = ((RW+1)'(walk_k_q) + 1'b1) == (RW+1)'(rs_eff);

	assign rd_byte  = rd_vb_s1 ? rd_data_s1 : wlrr_pkg::ERASED_BYTE;
	assign scan_hit = rd_vld_s1 && (rd_byte != cfg.empty_value);
	assign scan_end = (state_q == wlrr_pkg::ST_SCAN) && rd_vld_s1 && (scan_hit || rd_last_s1);

	assign go = !cmd_empty &&
		((cmd_head.op == wlrr_pkg::OP_READ) || (out_level < (OUT_AW+1)'(OUT_DEPTH)));
	// read credit: queued results plus the one in flight must leave a slot
	assign out_room = (LW'(out_level) + LW'(rd_vld_s1)) < LW'(OUT_DEPTH);

	always_comb begin
		state_d = state_q;
		case (state_q)
			wlrr_pkg::ST_IDLE: begin
				if (go) begin
					case (cmd_head.op)
						wlrr_pkg::OP_SCAN: state_d = wlrr_pkg::ST_SCAN;
						wlrr_pkg::OP_READ: state_d = wlrr_pkg::ST_RD_MOD;
						default: state_d = (cmd_head.pos == '0) ?
							wlrr_pkg::ST_ER_MOD : wlrr_pkg::ST_WR_MOD;
					endcase
				end
			end
			wlrr_pkg::ST_SCAN: begin
				if (scan_end)
					state_d = wlrr_pkg::ST_IDLE;
			end
			wlrr_pkg::ST_RD_MOD: begin
				if (mod_rsp.done)
					state_d = wlrr_pkg::ST_RD_WALK;
			end
			wlrr_pkg::ST_RD_WALK: begin
				if ((walk_k_q == rs_eff) && !rd_vld_s1)
					state_d = wlrr_pkg::ST_IDLE;
			end
			wlrr_pkg::ST_ER_MOD: begin
				if (mod_rsp.done)
					state_d = wlrr_pkg::ST_ERASE;
			end
			wlrr_pkg::ST_ERASE: begin
				if (walk_last)
					state_d = wlrr_pkg::ST_WR_MOD;
			end
			wlrr_pkg::ST_WR_MOD: begin
				if (mod_rsp.done)
					state_d = wlrr_pkg::ST_IDLE;
			end
			default: state_d = wlrr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop         = 1'b0;
		mod_req.start   = 1'b0;
		mod_req.x       = SW'(idx_q);
		mod_req.divisor = SW'(bs_eff);
		rd_issue        = 1'b0;
		rd_addr         = walk_e_q;
		rd_last         = 1'b0;
		mem_we          = 1'b0;
		mem_wa          = walk_e_q;
		mem_wd          = cfg.empty_value;
		res_push        = 1'b0;
		res.data        = rd_byte;
		res.index       = wlrr_pkg::INDEX_W'(rd_addr_s1);
		res.last        = rd_last_s1;
		case (state_q)
			wlrr_pkg::ST_IDLE: begin
				cmd_pop       = go;
				mod_req.start = go && (cmd_head.op != wlrr_pkg::OP_SCAN);
				if (cmd_head.op == wlrr_pkg::OP_WRITE)
					mod_req.x = SW'(idx_q) + SW'(cmd_head.pos);
			end
			wlrr_pkg::ST_SCAN: begin
				rd_issue = (scan_n_q < bs_eff) && !scan_end;
				rd_addr  = scan_n_q[AW-1:0];
				rd_last  = ((CW+1)'(scan_n_q) + 1'b1) == (CW+1)'(bs_eff);
				res_push = scan_end;
				res.data = '0;
				res.index = scan_hit ? wlrr_pkg::INDEX_W'(rd_addr_s1) : '0;
				res.last = 1'b1;
			end
			wlrr_pkg::ST_RD_WALK: begin
				rd_issue = (walk_k_q < rs_eff) && out_room;
				rd_last  = walk_last;
				res_push = rd_vld_s1;
			end
			wlrr_pkg::ST_ERASE: begin
				mem_we        = 1'b1;
				mod_req.start = walk_last;
				mod_req.x     = SW'(e_next) + SW'(cur_q.pos);
			end
			wlrr_pkg::ST_WR_MOD: begin
				mem_we    = mod_rsp.done;
				mem_wa    = mod_rsp.rem[AW-1:0];
				mem_wd    = cur_q.data;
				res_push  = mod_rsp.done;
				res.data  = cur_q.data;
				res.index = wlrr_pkg::INDEX_W'(mod_rsp.rem[AW-1:0]);
				res.last  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= wlrr_pkg::ST_IDLE;
			rd_vld_s1 <= 1'b0;
			scan_n_q  <= '0;
			walk_k_q  <= '0;
			idx_q     <= '0;
			vbit_q    <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;
			if (state_q == wlrr_pkg::ST_IDLE)
				scan_n_q <= '0;
			else if ((state_q == wlrr_pkg::ST_SCAN) && rd_issue)
				scan_n_q <= scan_n_q + 1'b1;
			if (mod_rsp.done &&
				((state_q == wlrr_pkg::ST_RD_MOD) || (state_q == wlrr_pkg::ST_ER_MOD)))
				walk_k_q <= '0;
			else if (((state_q == wlrr_pkg::ST_RD_WALK) && rd_issue) ||
				(state_q == wlrr_pkg::ST_ERASE))
				walk_k_q <= walk_k_q + 1'b1;
			if (scan_end)
				idx_q <= scan_hit ? rd_addr_s1 : '0;
			else if ((state_q == wlrr_pkg::ST_ERASE) && walk_last)
				idx_q <= e_next;
			if (mem_we)
				vbit_q[mem_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cur_q <= cmd_head;
		if (mod_rsp.done &&
			((state_q == wlrr_pkg::ST_RD_MOD) || (state_q == wlrr_pkg::ST_ER_MOD)))
			walk_e_q <= mod_rsp.rem[AW-1:0];
		else if (((state_q == wlrr_pkg::ST_RD_WALK) && rd_issue) ||
			(state_q == wlrr_pkg::ST_ERASE))
			walk_e_q <= e_next;
		if (rd_issue) begin
			rd_addr_s1 <= rd_addr;
			rd_last_s1 <= rd_last;
		end
		rd_data_s1 <= mem[rd_addr];
		rd_vb_s1   <= vbit_q[rd_addr];
		if (mem_we)
			mem[mem_wa] <= mem_wd;
	end

endmodule

// ===== sv/wear_leveling_record_ring_top.sv =====
// Top level of the wear-leveling record ring: config registers, queues, engine.
// Depends on wlrr_pkg, wlrr_front, wlrr_fifo, wlrr_mod and wlrr_engine.

// Items are handled one at a time by the engine while the front end keeps
// queuing up to two more. A rescan reads one store entry per cycle through
// the single read port. A read first wraps the record index in the serial
// remainder unit, then reads one store entry per cycle while the result
// queue has room. A write at a nonzero byte position passes through the
// remainder unit once; a write at position 0 first erases the old record one
// entry per cycle, then wraps the write address in the remainder unit again.
// The store comes out of reset erased at once through per-entry valid bits,
// with no clearing pass.
module wear_leveling_record_ring_top #(
	parameter int STORE_DEPTH = wlrr_pkg::STORE_DEPTH_DEF,
	parameter int MAX_RECORD  = wlrr_pkg::MAX_RECORD_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [wlrr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wlrr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [wlrr_pkg::FUNC_W-1:0]       func,
	input  logic [wlrr_pkg::BYTE_W-1:0]       data_byte,
	input  logic [wlrr_pkg::POS_W-1:0]        byte_position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [wlrr_pkg::BYTE_W-1:0]       read_byte,
	output logic [wlrr_pkg::INDEX_W-1:0]      ring_index,
	output logic                              last
);

	localparam int CMD_W = $bits(wlrr_pkg::cmd_t);
	localparam int RES_W = $bits(wlrr_pkg::res_t);

	wlrr_pkg::cfg_t     cfg_q;
	wlrr_pkg::cmd_t     cmd_in;
	wlrr_pkg::cmd_t     cmd_head;
	wlrr_pkg::res_t     res_in;
	wlrr_pkg::res_t     res_head;
	wlrr_pkg::mod_req_t mod_req;
	wlrr_pkg::mod_rsp_t mod_rsp;

	logic                           cmd_push;
	logic                           cmd_pop;
	logic                           cmd_full;
	logic                           cmd_empty;
	logic                           res_push;
	logic                           res_empty;
	logic [wlrr_pkg::OUT_FIFO_AW:0] out_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_size  <= wlrr_pkg::BLOCK_RESET;
			cfg_q.record_size <= wlrr_pkg::RECORD_RESET;
			cfg_q.empty_value <= wlrr_pkg::EMPTY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wlrr_pkg::REG_BLOCK_SIZE:
					cfg_q.block_size <= cfg_data[wlrr_pkg::BLOCK_W-1:0];
				wlrr_pkg::REG_RECORD_SIZE:
					cfg_q.record_size <= cfg_data[wlrr_pkg::RECORD_W-1:0];
				wlrr_pkg::REG_EMPTY_VALUE:
					cfg_q.empty_value <= cfg_data[wlrr_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	wlrr_front u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.data_byte     (data_byte),
		.byte_position (byte_position),
		.cmd_full      (cmd_full),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in)
	);

	wlrr_fifo #(
		.WIDTH (CMD_W),
		.AW    (wlrr_pkg::CMD_FIFO_AW)
	) u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.pop       (cmd_pop),
		.pop_data  (cmd_head),
		.full      (cmd_full),
		.empty     (cmd_empty),
		.level     ()
	);

	wlrr_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	wlrr_engine #(
		.STORE_DEPTH (STORE_DEPTH),
		.MAX_RECORD  (MAX_RECORD),
		.OUT_AW      (wlrr_pkg::OUT_FIFO_AW)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_head),
		.cmd_pop   (cmd_pop),
		.out_level (out_level),
		.res_push  (res_push),
		.res       (res_in),
		.mod_req   (mod_req),
		.mod_rsp   (mod_rsp)
	);

	wlrr_fifo #(
		.WIDTH (RES_W),
		.AW    (wlrr_pkg::OUT_FIFO_AW)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_in),
		.pop       (out_valid && !out_stall),
		.pop_data  (res_head),
		.full      (),
		.empty     (res_empty),
		.level     (out_level)
	);

	assign out_valid  = !res_empty;
	assign read_byte  = res_head.data;
	assign ring_index = res_head.index;
	assign last       = res_head.last;

endmodule

// ===== tb/wear_leveling_record_ring_top_tb.sv =====
// Self-checking testbench for wear_leveling_record_ring_top: directed table, then random traffic.
// Depends on wlrr_pkg and the record ring RTL; results checked against an in-bench predictor.
module wear_leveling_record_ring_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FUNC_W          = wlrr_pkg::FUNC_W;
	localparam int BYTE_W          = wlrr_pkg::BYTE_W;
	localparam int POS_W           = wlrr_pkg::POS_W;
	localparam int INDEX_W         = wlrr_pkg::INDEX_W;
	localparam int BLOCK_W         = wlrr_pkg::BLOCK_W;
	localparam int RECORD_W        = wlrr_pkg::RECORD_W;
	localparam int CFG_IDX_W       = wlrr_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W      = wlrr_pkg::CFG_DATA_W;
	localparam int STORE_DEPTH_DEF = wlrr_pkg::STORE_DEPTH_DEF;
	localparam int MAX_RECORD_DEF  = wlrr_pkg::MAX_RECORD_DEF;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES   = 300;   // longer than the slowest item, a full-ring rescan
	localparam int CYCLE_LIMIT     = 2_000_000;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int RANDOM_PHASES   = 6;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [FUNC_W-1:0]   f;
		logic [BYTE_W-1:0]   d;
		logic [POS_W-1:0]    p;
		logic                typed;
		wlrr_pkg::res_t      want;
		logic [BLOCK_W-1:0]  bs;
		logic [RECORD_W-1:0] rs;
		logic [BYTE_W-1:0]   ev;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [FUNC_W-1:0]     func = '0;
	logic [BYTE_W-1:0]     data_byte = '0;
	logic [POS_W-1:0]      byte_position = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [BYTE_W-1:0]     read_byte;
	logic [INDEX_W-1:0]    ring_index;
	logic                  last;

	// predictor state
	logic [BYTE_W-1:0]   ring_image [STORE_DEPTH_DEF];
	logic [INDEX_W-1:0]  index_image;
	logic [BLOCK_W-1:0]  block_cfg;
	logic [RECORD_W-1:0] record_cfg;
	logic [BYTE_W-1:0]   empty_cfg;
	wlrr_pkg::res_t      awaited[$];
	wlrr_pkg::res_t      step_out[$];
	dir_row_t            dir_rows[$];

	wlrr_pkg::res_t want_r;
	bit   no_idle = 1'b0;
	int   cycle_count = 0;
	int   mismatches = 0;
	int   results_checked = 0;
	int   txns_sent = 0;
	int   ignored_sent = 0;
	int   settings_applied = 0;

	wear_leveling_record_ring_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.data_byte     (data_byte),
		.byte_position (byte_position),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_byte     (read_byte),
		.ring_index    (ring_index),
		.last          (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_block();
		if (block_cfg == '0) return 1;
		if (block_cfg > STORE_DEPTH_DEF) return STORE_DEPTH_DEF;
		return int'(block_cfg);
	endfunction

	function automatic int eff_record();
		if (record_cfg == '0) return 1;
		if (record_cfg > MAX_RECORD_DEF) return MAX_RECORD_DEF;
		return int'(record_cfg);
	endfunction

	function automatic int ring_slot(input int offset);
		return (int'(index_image) + offset) % eff_block();
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		// bias toward the empty value so rescans and erases have something to find
		if ($urandom_range(0, 3) == 0) return empty_cfg;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	task automatic ring_predict(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] d,
			input logic [POS_W-1:0] p);
		int             bs;
		int             rs;
		int             n;
		int             e;
		int             found;
		wlrr_pkg::res_t r;
		step_out.delete();
		bs = eff_block();
		rs = eff_record();
		case (f)
			wlrr_pkg::FUNC_RESCAN: begin
				found = 0;
				for (n = 0; n < bs; n++) begin
					if (ring_image[n] != empty_cfg) begin
						found = n;
						break;
					end
				end
				index_image = found[INDEX_W-1:0];
				r.data = '0;
				r.index = index_image;
				r.last = 1'b1;
				step_out.push_back(r);
			end
			wlrr_pkg::FUNC_READ: begin
				for (n = 0; n < rs; n++) begin
					e = ring_slot(n);
					r.data = ring_image[e];
					r.index = e[INDEX_W-1:0];
					r.last = (n == rs - 1);
					step_out.push_back(r);
				end
			end
			wlrr_pkg::FUNC_WRITE: begin
				// position 0 erases the old record, then moves on to the next one
				if (p == '0) begin
					for (n = 0; n < rs; n++)
						ring_image[ring_slot(n)] = empty_cfg;
					index_image = INDEX_W'(ring_slot(rs));
				end
				e = ring_slot(int'(p));
				ring_image[e] = d;
				r.data = d;
				r.index = e[INDEX_W-1:0];
				r.last = 1'b1;
				step_out.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited.size() == 0) begin
				report_mismatch("unexpected transaction, ring_index", int'(ring_index), 0);
			end else begin
				want_r = awaited.pop_front();
				if (read_byte !== want_r.data)
					report_mismatch("read_byte", int'(read_byte), int'(want_r.data));
				if (ring_index !== want_r.index)
					report_mismatch("ring_index", int'(ring_index), int'(want_r.index));
				if (last !== want_r.last)
					report_mismatch("last", int'(last), int'(want_r.last));
				results_checked++;
			end
		end
		out_stall <= !no_idle && ($urandom_range(0, 99) < 12);
	end

	task automatic send_txn(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] d,
			input logic [POS_W-1:0] p, input logic typed, input wlrr_pkg::res_t typed_r);
		while (!no_idle && $urandom_range(0, 99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		data_byte <= d;
		byte_position <= p;
		do @(posedge clk); while (in_stall);
		ring_predict(f, d, p);
		if (typed)
			awaited.push_back(typed_r);
		else
			foreach (step_out[k]) awaited.push_back(step_out[k]);
		if (f == FUNC_UNUSED) ignored_sent++;
		else txns_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [BLOCK_W-1:0] bs, input logic [RECORD_W-1:0] rs,
			input logic [BYTE_W-1:0] ev);
		cfg_we <= 1'b1;
		cfg_index <= wlrr_pkg::REG_BLOCK_SIZE;
		cfg_data <= CFG_DATA_W'(bs);
		@(posedge clk);
		block_cfg = bs;
		cfg_index <= wlrr_pkg::REG_RECORD_SIZE;
		cfg_data <= CFG_DATA_W'(rs);
		@(posedge clk);
		record_cfg = rs;
		cfg_index <= wlrr_pkg::REG_EMPTY_VALUE;
		cfg_data <= CFG_DATA_W'(ev);
		@(posedge clk);
		empty_cfg = ev;
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_applied++;
	endtask

	task automatic add_item(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] d,
			input logic [POS_W-1:0] p, input logic typed, input logic [BYTE_W-1:0] wd,
			input logic [INDEX_W-1:0] wi);
		dir_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.f = f;
		r.d = d;
		r.p = p;
		r.typed = typed;
		r.want.data = wd;
		r.want.index = wi;
		r.want.last = 1'b1;
		dir_rows.push_back(r);
	endtask

	task automatic add_cfg(input logic [BLOCK_W-1:0] bs, input logic [RECORD_W-1:0] rs,
			input logic [BYTE_W-1:0] ev);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.bs = bs;
		r.rs = rs;
		r.ev = ev;
		dir_rows.push_back(r);
	endtask

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("wear_leveling_record_ring_top_tb failed");
		$finish;
	end

	initial begin : stimulus
		int             ph;
		int             n;
		int             q;
		int             pick;
		int             len;
		bit             held_off;
		wlrr_pkg::res_t no_typed;
		no_typed = '0;
		held_off = 1'b0;
		foreach (ring_image[k]) ring_image[k] = wlrr_pkg::ERASED_BYTE;
		index_image = '0;
		block_cfg = wlrr_pkg::BLOCK_RESET;
		record_cfg = wlrr_pkg::RECORD_RESET;
		empty_cfg = wlrr_pkg::EMPTY_RESET;

		// reset defaults: erased ring, index 0, one-byte records
		add_item(wlrr_pkg::FUNC_RESCAN, 8'h00, 6'd0,  1'b1, 8'h00, 8'd0);
		add_item(wlrr_pkg::FUNC_READ,   8'h00, 6'd0,  1'b1, 8'hFF, 8'd0);
		add_item(wlrr_pkg::FUNC_WRITE,  8'h00, 6'd0,  1'b1, 8'h00, 8'd1);
		add_item(wlrr_pkg::FUNC_WRITE,  8'hFF, 6'd0,  1'b1, 8'hFF, 8'd2);
		add_item(wlrr_pkg::FUNC_RESCAN, 8'h00, 6'd0,  1'b1, 8'h00, 8'd0);
		add_item(FUNC_UNUSED,           8'hFF, 6'd63, 1'b0, 8'h00, 8'd0);
		add_item(wlrr_pkg::FUNC_WRITE,  8'hA5, 6'd63, 1'b1, 8'hA5, 8'd63);
		add_item(wlrr_pkg::FUNC_RESCAN, 8'h00, 6'd0,  1'b1, 8'h00, 8'd63);
		add_item(wlrr_pkg::FUNC_READ,   8'h00, 6'd0,  1'b1, 8'hA5, 8'd63);
		// zero sizes clamp to one, a one-entry ring
		add_cfg(9'd0, 7'd0, 8'h00);
		add_item(wlrr_pkg::FUNC_WRITE,  8'h7E, 6'd0,  1'b1, 8'h7E, 8'd0);
		add_item(wlrr_pkg::FUNC_RESCAN, 8'h00, 6'd0,  1'b1, 8'h00, 8'd0);
		add_item(wlrr_pkg::FUNC_READ,   8'h00, 6'd0,  1'b1, 8'h7E, 8'd0);
		add_item(wlrr_pkg::FUNC_WRITE,  8'h81, 6'd63, 1'b1, 8'h81, 8'd0);
		// oversize values clamp to the full ring and the largest record
		add_cfg(9'd511, 7'd127, 8'h5A);
		add_item(wlrr_pkg::FUNC_READ,   8'h00, 6'd0,  1'b0, 8'h00, 8'd0);
		add_item(wlrr_pkg::FUNC_WRITE,  8'hC3, 6'd0,  1'b0, 8'h00, 8'd0);
		add_item(wlrr_pkg::FUNC_WRITE,  8'h3C, 6'd63, 1'b0, 8'h00, 8'd0);
		add_item(wlrr_pkg::FUNC_READ,   8'h00, 6'd0,  1'b0, 8'h00, 8'd0);
		add_item(wlrr_pkg::FUNC_RESCAN, 8'h00, 6'd0,  1'b0, 8'h00, 8'd0);
		// record larger than the ring, index left beyond the new block size
		add_cfg(9'd3, 7'd64, 8'hFF);
		add_item(wlrr_pkg::FUNC_READ,   8'h00, 6'd0,  1'b0, 8'h00, 8'd0);
		add_item(wlrr_pkg::FUNC_WRITE,  8'h11, 6'd0,  1'b0, 8'h00, 8'd0);
		add_item(wlrr_pkg::FUNC_WRITE,  8'h22, 6'd5,  1'b0, 8'h00, 8'd0);
		add_item(wlrr_pkg::FUNC_READ,   8'h00, 6'd0,  1'b0, 8'h00, 8'd0);
		add_item(wlrr_pkg::FUNC_RESCAN, 8'h00, 6'd0,  1'b0, 8'h00, 8'd0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG) begin
				drain_results();
				set_config(dir_rows[k].bs, dir_rows[k].rs, dir_rows[k].ev);
			end else begin
				send_txn(dir_rows[k].f, dir_rows[k].d, dir_rows[k].p, dir_rows[k].typed,
					dir_rows[k].want);
			end
		end

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_results();
			no_idle = (ph == 0);
			case (ph)
				0: set_config(BLOCK_W'($urandom_range(1, 16)), RECORD_W'($urandom_range(1, 4)),
					BYTE_W'($urandom_range(0, 255)));
				1: set_config(wlrr_pkg::BLOCK_RESET, wlrr_pkg::RECORD_RESET,
					wlrr_pkg::EMPTY_RESET);
				2: set_config(BLOCK_W'($urandom_range(2, 256)), RECORD_W'($urandom_range(1, 8)),
					BYTE_W'($urandom_range(0, 255)));
				3: set_config(9'd1, 7'd64, BYTE_W'($urandom_range(0, 255)));
				4: set_config(BLOCK_W'($urandom_range(0, 511)), RECORD_W'($urandom_range(0, 127)),
					BYTE_W'($urandom_range(0, 255)));
				default: set_config(BLOCK_W'($urandom_range(4, 64)),
					RECORD_W'($urandom_range(2, 6)), 8'h00);
			endcase
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				if (ph == 2 && n >= ITEMS_PER_PHASE / 2 && !held_off) begin
					// hold the sender until the ring has answered everything
					drain_results();
					held_off = 1'b1;
				end
				pick = int'($urandom_range(0, 99));
				if (pick < 35) begin
					// one whole record, now and then cut short
					len = eff_record();
					if (len > 8 && $urandom_range(0, 1) == 1)
						len = int'($urandom_range(1, len - 1));
					for (q = 0; q < len; q++) begin
						send_txn(wlrr_pkg::FUNC_WRITE, pick_byte(), POS_W'(q), 1'b0, no_typed);
						n++;
					end
				end else if (pick < 50) begin
					send_txn(wlrr_pkg::FUNC_WRITE, pick_byte(), POS_W'($urandom_range(0, 63)),
						1'b0, no_typed);
					n++;
				end else if (pick < 75) begin
					send_txn(wlrr_pkg::FUNC_READ, pick_byte(), POS_W'($urandom_range(0, 63)),
						1'b0, no_typed);
					n++;
				end else if (pick < 88) begin
					send_txn(wlrr_pkg::FUNC_RESCAN, pick_byte(), POS_W'($urandom_range(0, 63)),
						1'b0, no_typed);
					n++;
				end else if (pick < 93) begin
					send_txn(FUNC_UNUSED, pick_byte(), POS_W'($urandom_range(0, 63)), 1'b0,
						no_typed);
				end else begin
					send_txn(wlrr_pkg::FUNC_WRITE, empty_cfg, '0, 1'b0, no_typed);
					n++;
				end
			end
		end
		no_idle = 1'b0;
		drain_results();

		$display("Covered %0d transactions plus %0d ignored selectors over %0d register settings.",
			txns_sent, ignored_sent, settings_applied);
		$display("Compared %0d results field by field, %0d mismatches.", results_checked,
			mismatches);
		if (mismatches == 0) begin
			$display("wear_leveling_record_ring_top_tb passed");
		end else begin
			$display("wear_leveling_record_ring_top_tb failed");
		end
		$finish;
	end

endmodule
